// ===== design/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared constants, codes and the token and write-command types of the
// named service registry table.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int TABLE_ENTRIES  = 64;
  localparam int FIRST_SERVICE  = 8;
  localparam int RESERVED_SLOTS = 8;
  localparam int NAME_BYTES     = 16;

  localparam int NAME_W = NAME_BYTES * 8;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  // common width for slot numbers, counts and the 6-bit call index
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

  typedef enum logic [1:0] {
    OP_REG_SERVICE  = 2'd0,
    OP_QUERY        = 2'd1,
    OP_RESOLVE      = 2'd2,
    OP_REG_RESERVED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_NAME  = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_UNREG     = 3'd5,
    ST_BAD_INDEX = 3'd6
  } status_t;

  // request token that walks the row of cells
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [NAME_W-1:0] name;
    logic              name_ok;
    logic [31:0]       hnd;
    logic [31:0]       arg;
    logic [5:0]        idx;
    logic              hit;
    logic [CMP_W-1:0]  hit_idx;
    logic [31:0]       slot_hnd;
    logic [31:0]       slot_arg;
  } tok_t;

  // entry write broadcast to all cells
  typedef struct packed {
    logic              valid;
    logic [CMP_W-1:0]  slot;
    logic [NAME_W-1:0] name;
    logic [31:0]       hnd;
    logic [31:0]       arg;
  } wr_t;

endpackage

// ===== design/nsr_req_if.sv =====
// ----------------------------------------------------------------------------
// nsr_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface nsr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] name_word0;
  logic [31:0] name_word1;
  logic [31:0] name_word2;
  logic [31:0] name_word3;
  logic [31:0] handler;
  logic [31:0] handler_arg;
  logic [5:0]  call_index;

  modport source (
    output valid, opcode, name_word0, name_word1, name_word2, name_word3,
           handler, handler_arg, call_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, name_word0, name_word1, name_word2, name_word3,
           handler, handler_arg, call_index,
    output ready
  );
endinterface

// ===== design/nsr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nsr_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface nsr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  service_index;
  logic [31:0] handler_out;
  logic [31:0] handler_arg_out;

  modport source (
    output valid, status, service_index, handler_out, handler_arg_out,
    input  ready
  );
  modport sink (
    input  valid, status, service_index, handler_out, handler_arg_out,
    output ready
  );
endinterface

// ===== design/nsr_name_unit.sv =====
// ----------------------------------------------------------------------------
// nsr_name_unit
// Unpacks the four name words, clears every byte after the first NUL and
// flags a name with a nonzero first byte and a NUL within the field.
// ----------------------------------------------------------------------------
module nsr_name_unit (
  input  logic [31:0]                  name_word0,
  input  logic [31:0]                  name_word1,
  input  logic [31:0]                  name_word2,
  input  logic [31:0]                  name_word3,
  output logic [nsr_pkg::NAME_W-1:0]   name_clean,
  output logic                         name_ok
);

  logic [nsr_pkg::NAME_W-1:0]     raw;
  logic [nsr_pkg::NAME_BYTES-1:0] zero_byte;
  logic [nsr_pkg::NAME_BYTES-1:0] keep;

  assign raw = {name_word3, name_word2, name_word1, name_word0};

  // flag the NUL bytes
  always_comb begin
    for (int b = 0; b < nsr_pkg::NAME_BYTES; b++) begin
      zero_byte[b] = (raw[b*8 +: 8] == 8'h00);
    end
  end

  // keep a byte only when no NUL stands below it
  always_comb begin
    for (int b = 0; b < nsr_pkg::NAME_BYTES; b++) begin
      keep[b] = ((zero_byte & (((nsr_pkg::NAME_BYTES)'(1) << b)
                  - (nsr_pkg::NAME_BYTES)'(1))) == '0);
      name_clean[b*8 +: 8] = keep[b] ? raw[b*8 +: 8] : 8'h00;
    end
  end

  assign name_ok = !zero_byte[0] && (|zero_byte[nsr_pkg::NAME_BYTES-1:1]);

endmodule

// ===== design/nsr_cell.sv =====
// ----------------------------------------------------------------------------
// nsr_cell
// One table slot: holds name, handler and argument, checks the passing
// request token against them and hands the token on in the next cycle.
// ----------------------------------------------------------------------------
module nsr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [nsr_pkg::CMP_W-1:0] slot,
  input  logic [nsr_pkg::CMP_W-1:0] used_count,
  input  nsr_pkg::wr_t              wr,
  input  nsr_pkg::tok_t             tok_in,
  output nsr_pkg::tok_t             tok_out
);

  logic [nsr_pkg::NAME_W-1:0] name_q;
  logic [31:0]                hnd_q;
  logic [31:0]                arg_q;
  nsr_pkg::tok_t              tok_next;
  logic                       in_service;
  logic                       idx_match;
  logic                       wr_here;

  assign wr_here    = wr.valid && (wr.slot == slot);
  assign in_service = (slot >= nsr_pkg::CMP_W'(nsr_pkg::FIRST_SERVICE)) &&
                      (slot < used_count);
  assign idx_match  = ({{(nsr_pkg::CMP_W-6){1'b0}}, tok_in.idx} == slot);

  // update the token with this slot's contribution
  always_comb begin
    tok_next = tok_in;
    case (tok_in.op)
      nsr_pkg::OP_REG_SERVICE, nsr_pkg::OP_QUERY: begin
        if (!tok_in.hit && tok_in.name_ok && in_service && (name_q == tok_in.name)) begin
          tok_next.hit     = 1'b1;
          tok_next.hit_idx = slot;
        end
      end
      nsr_pkg::OP_RESOLVE, nsr_pkg::OP_REG_RESERVED: begin
        if (idx_match) begin
          tok_next.slot_hnd = hnd_q;
          tok_next.slot_arg = arg_q;
        end
      end
      default: begin
        tok_next = tok_in;
      end
    endcase
  end

  // advance the token
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.op       <= tok_next.op;
    tok_out.name     <= tok_next.name;
    tok_out.name_ok  <= tok_next.name_ok;
    tok_out.hnd      <= tok_next.hnd;
    tok_out.arg      <= tok_next.arg;
    tok_out.idx      <= tok_next.idx;
    tok_out.hit      <= tok_next.hit;
    tok_out.hit_idx  <= tok_next.hit_idx;
    tok_out.slot_hnd <= tok_next.slot_hnd;
    tok_out.slot_arg <= tok_next.slot_arg;
  end

  // hold the handler; zero marks a free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hnd_q <= '0;
    end else if (wr_here) begin
      hnd_q <= wr.hnd;
    end
  end

  // hold name and argument
  always_ff @(posedge clk) begin
    if (wr_here) begin
      name_q <= wr.name;
      arg_q  <= wr.arg;
    end
  end

endmodule

// ===== design/named_service_registry_table_unit.sv =====
// ----------------------------------------------------------------------------
// named_service_registry_table_unit
// Table of named call entries with service registration, name query,
// reserved-slot registration and call resolve.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink) carries one request per transfer: opcode, the 16-byte name in
//   four words, handler, handler argument and call index. rsp (source)
//   returns exactly one result per request: status, service index, handler
//   and argument.
//   Each request token walks a row of TABLE_ENTRIES slot cells, one cell per
//   cycle; every cell compares its own entry. The result is decided when the
//   token leaves the last cell, the table write is broadcast in the next cycle.
//   The result passes the holding register and then the output register
//   before response valid. One request is in flight at a time; req is ready
//   again once the result sits in the output register, so a new request runs
//   while a response waits.
//   If rsp stalls, a finished result waits in a holding register and
//   req.ready stays low until the output register frees up.
//   Reset clears all handlers to zero, sets the used count to FIRST_SERVICE
//   and empties the token row and the output; no clearing pass is needed.
// ----------------------------------------------------------------------------
module named_service_registry_table_unit (
  input  logic          clk,
  input  logic          rst,
  nsr_req_if.sink       req,
  nsr_rsp_if.source     rsp
);

  localparam int N = nsr_pkg::TABLE_ENTRIES;

  nsr_pkg::tok_t              chain [N+1];
  nsr_pkg::tok_t              tok_entry;
  nsr_pkg::wr_t               wr;
  nsr_pkg::wr_t               wr_next;
  logic [nsr_pkg::NAME_W-1:0] name_clean;
  logic                       name_ok;
  logic [nsr_pkg::CMP_W-1:0]  used_count;
  logic [nsr_pkg::CMP_W-1:0]  used_count_next;
  logic                       run;
  logic                       accept;
  nsr_pkg::tok_t              tok_exit;
  logic [nsr_pkg::CMP_W-1:0]  idx_ext;

  nsr_pkg::status_t           fin_status;
  nsr_pkg::status_t           fin_status_next;
  logic [5:0]                 fin_sidx;
  logic [5:0]                 fin_sidx_next;
  logic [31:0]                fin_hout;
  logic [31:0]                fin_hout_next;
  logic [31:0]                fin_aout;
  logic [31:0]                fin_aout_next;
  logic                       fin_valid;
  logic [nsr_pkg::CMP_W-1:0]  sidx_wide;

  logic                       out_valid;
  nsr_pkg::status_t           out_status;
  logic [5:0]                 out_sidx;
  logic [31:0]                out_hout;
  logic [31:0]                out_aout;
  logic                       out_load;

  assign req.ready = !run && !fin_valid;
  assign accept    = req.valid && req.ready;
  assign out_load  = fin_valid && (!out_valid || rsp.ready);

  nsr_name_unit u_name (
    .name_word0 (req.name_word0),
    .name_word1 (req.name_word1),
    .name_word2 (req.name_word2),
    .name_word3 (req.name_word3),
    .name_clean (name_clean),
    .name_ok    (name_ok)
  );

  // build the entry token
  always_comb begin
    tok_entry.valid    = accept;
    tok_entry.op       = nsr_pkg::op_t'(req.opcode);
    tok_entry.name     = name_clean;
    tok_entry.name_ok  = name_ok;
    tok_entry.hnd      = req.handler;
    tok_entry.arg      = req.handler_arg;
    tok_entry.idx      = req.call_index;
    tok_entry.hit      = 1'b0;
    tok_entry.hit_idx  = '0;
    tok_entry.slot_hnd = '0;
    tok_entry.slot_arg = '0;
  end

  assign chain[0] = tok_entry;

  // row of slot cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    nsr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .slot       (nsr_pkg::CMP_W'(i)),
      .used_count (used_count),
      .wr         (wr),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1])
    );
  end

  assign tok_exit = chain[N];
  assign idx_ext  = {{(nsr_pkg::CMP_W-6){1'b0}}, tok_exit.idx};

  // decide the result and the table write when the token leaves the row
  always_comb begin
    fin_status_next = nsr_pkg::ST_OK;
    sidx_wide       = '0;
    fin_hout_next   = '0;
    fin_aout_next   = '0;
    used_count_next = used_count;
    wr_next.valid   = 1'b0;
    wr_next.slot    = idx_ext;
    wr_next.name    = '0;
    wr_next.hnd     = tok_exit.hnd;
    wr_next.arg     = tok_exit.arg;
    case (tok_exit.op)
      nsr_pkg::OP_REG_SERVICE: begin
        if (!tok_exit.name_ok) begin
          fin_status_next = nsr_pkg::ST_BAD_NAME;
        end else if (tok_exit.hit) begin
          fin_status_next = nsr_pkg::ST_EXISTS;
        end else if (used_count >= nsr_pkg::CMP_W'(nsr_pkg::TABLE_ENTRIES)) begin
          fin_status_next = nsr_pkg::ST_FULL;
        end else begin
          sidx_wide       = used_count;
          used_count_next = used_count + nsr_pkg::CMP_W'(1);
          wr_next.valid   = 1'b1;
          wr_next.slot    = used_count;
          wr_next.name    = tok_exit.name;
        end
      end
      nsr_pkg::OP_QUERY: begin
        if (!tok_exit.name_ok) begin
          fin_status_next = nsr_pkg::ST_BAD_NAME;
        end else if (!tok_exit.hit) begin
          fin_status_next = nsr_pkg::ST_NOT_FOUND;
        end else begin
          sidx_wide = tok_exit.hit_idx;
        end
      end
      nsr_pkg::OP_RESOLVE: begin
        if (idx_ext >= nsr_pkg::CMP_W'(nsr_pkg::TABLE_ENTRIES)) begin
          fin_status_next = nsr_pkg::ST_BAD_INDEX;
        end else if (tok_exit.slot_hnd == '0) begin
          fin_status_next = nsr_pkg::ST_UNREG;
        end else begin
          sidx_wide     = idx_ext;
          fin_hout_next = tok_exit.slot_hnd;
          fin_aout_next = tok_exit.slot_arg;
        end
      end
      nsr_pkg::OP_REG_RESERVED: begin
        if ((idx_ext >= nsr_pkg::CMP_W'(nsr_pkg::RESERVED_SLOTS)) ||
            (idx_ext >= nsr_pkg::CMP_W'(nsr_pkg::TABLE_ENTRIES))) begin
          fin_status_next = nsr_pkg::ST_BAD_INDEX;
        end else if (tok_exit.slot_hnd != '0) begin
          fin_status_next = nsr_pkg::ST_EXISTS;
        end else begin
          sidx_wide     = idx_ext;
          wr_next.valid = 1'b1;
        end
      end
      default: begin
        fin_status_next = nsr_pkg::ST_OK;
      end
    endcase
    fin_sidx_next = sidx_wide[5:0];
  end

  // track the token in flight, the used count and the write broadcast
  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= 1'b0;
      used_count <= nsr_pkg::CMP_W'(nsr_pkg::FIRST_SERVICE);
      wr.valid   <= 1'b0;
    end else begin
      if (accept) begin
        run <= 1'b1;
      end else if (tok_exit.valid) begin
        run <= 1'b0;
      end
      if (tok_exit.valid) begin
        used_count <= used_count_next;
      end
      wr.valid <= tok_exit.valid && wr_next.valid;
    end
    wr.slot <= wr_next.slot;
    wr.name <= wr_next.name;
    wr.hnd  <= wr_next.hnd;
    wr.arg  <= wr_next.arg;
  end

  // hold the finished result until the output register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (tok_exit.valid) begin
      fin_valid <= 1'b1;
    end else if (out_load) begin
      fin_valid <= 1'b0;
    end
    if (tok_exit.valid) begin
      fin_status <= fin_status_next;
      fin_sidx   <= fin_sidx_next;
      fin_hout   <= fin_hout_next;
      fin_aout   <= fin_aout_next;
    end
  end

  // output register: load on a free slot, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_status <= fin_status;
      out_sidx   <= fin_sidx;
      out_hout   <= fin_hout;
      out_aout   <= fin_aout;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.service_index   = out_sidx;
  assign rsp.handler_out     = out_hout;
  assign rsp.handler_arg_out = out_aout;

endmodule
